[hw/rtl/vt52_pkg.sv]
`timescale 1ns / 1ps
package vt52_pkg;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] POS_BIAS = 8'h20;
  localparam logic [7:0] ID_SLASH = 8'h2F;
  localparam logic [7:0] ID_K     = 8'h4B;

  // final letters of the escape sequences, also the key reply letters
  localparam logic [7:0] SEQ_UP    = 8'h41;
  localparam logic [7:0] SEQ_DOWN  = 8'h42;
  localparam logic [7:0] SEQ_RIGHT = 8'h43;
  localparam logic [7:0] SEQ_LEFT  = 8'h44;
  localparam logic [7:0] SEQ_HOME  = 8'h48;
  localparam logic [7:0] SEQ_REVLF = 8'h49;
  localparam logic [7:0] SEQ_EOS   = 8'h4A;
  localparam logic [7:0] SEQ_EOL   = 8'h4B;
  localparam logic [7:0] SEQ_PLACE = 8'h59;
  localparam logic [7:0] SEQ_IDENT = 8'h5A;

  localparam logic [3:0] ACT_GLYPH = 4'd0;
  localparam logic [3:0] ACT_BS    = 4'd1;
  localparam logic [3:0] ACT_TAB   = 4'd2;
  localparam logic [3:0] ACT_LF    = 4'd3;
  localparam logic [3:0] ACT_CR    = 4'd4;
  localparam logic [3:0] ACT_UP    = 4'd5;
  localparam logic [3:0] ACT_DOWN  = 4'd6;
  localparam logic [3:0] ACT_RIGHT = 4'd7;
  localparam logic [3:0] ACT_LEFT  = 4'd8;
  localparam logic [3:0] ACT_HOME  = 4'd9;
  localparam logic [3:0] ACT_REVLF = 4'd10;
  localparam logic [3:0] ACT_EOS   = 4'd11;
  localparam logic [3:0] ACT_EOL   = 4'd12;
  localparam logic [3:0] ACT_PLACE = 4'd13;
  localparam logic [3:0] ACT_REPLY = 4'd14;

  localparam logic [1:0] PS_GROUND = 2'd0;
  localparam logic [1:0] PS_ESC    = 2'd1;
  localparam logic [1:0] PS_ROW    = 2'd2;
  localparam logic [1:0] PS_COL    = 2'd3;

  localparam logic [2:0] KEY_UP    = 3'd0;
  localparam logic [2:0] KEY_DOWN  = 3'd1;
  localparam logic [2:0] KEY_RIGHT = 3'd2;
  localparam logic [2:0] KEY_LEFT  = 3'd3;
  localparam logic [2:0] KEY_HOME  = 3'd4;

  // decoded item: up to three beats sharing one action
  typedef struct packed {
    logic [1:0] count;
    logic [3:0] action;
    logic [7:0] row;
    logic [7:0] col;
    logic [6:0] glyph;
    logic [7:0] reply1;
    logic [1:0] state_next;
    logic [7:0] pending_row_next;
  } dec_t;

  function automatic logic [7:0] key_letter(input logic [2:0] key);
    logic [7:0] r;
    case (key)
      KEY_UP:    r = SEQ_UP;
      KEY_DOWN:  r = SEQ_DOWN;
      KEY_RIGHT: r = SEQ_RIGHT;
      KEY_LEFT:  r = SEQ_LEFT;
      KEY_HOME:  r = SEQ_HOME;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/vt52_if.sv]
`timescale 1ns / 1ps
interface vt52_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic [2:0] key_code;

  modport source (output valid, kind, byte_value, key_code, input ready);
  modport sink (input valid, kind, byte_value, key_code, output ready);
endinterface

interface vt52_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] target_row;
  logic [7:0] target_col;
  logic [6:0] glyph;
  logic [7:0] reply_byte;
  logic       last;

  modport source (output valid, action, target_row, target_col, glyph, reply_byte, last,
                  input ready);
  modport sink (input valid, action, target_row, target_col, glyph, reply_byte, last,
                output ready);
endinterface

[hw/rtl/vt52_escape_parser.sv]
`timescale 1ns / 1ps
// the first result beat is registered: valid in the cycle after its input beat is taken
// throughput: one input beat per cycle while each gives at most one result and the
//   receiver takes it; an input giving several results (ESC Z, key) holds off the next
//   input until its last result beat is taken
// reset: synchronous, active high; parser returns to ground, pending row cleared,
//   no result held
module vt52_escape_parser (
  input logic         clk,
  input logic         rst,
  vt52_in_if.sink     in_ch,
  vt52_out_if.source  out_ch
);
  import vt52_pkg::*;

  logic [1:0] parse_state;
  logic [7:0] pending_row;
  dec_t       dec;

  // held result bundle; count zero means empty
  logic [1:0] cnt;
  logic [1:0] idx;
  logic [3:0] action;
  logic [7:0] row;
  logic [7:0] col;
  logic [6:0] glyph;
  logic [7:0] reply1;

  logic last_beat;
  logic out_fire;
  logic in_fire;

  vt52_dec u_dec (
    .kind        (in_ch.kind),
    .byte_value  (in_ch.byte_value),
    .key_code    (in_ch.key_code),
    .parse_state (parse_state),
    .pending_row (pending_row),
    .dec         (dec)
  );

  assign last_beat = (cnt != 2'd0) && (idx == cnt - 2'd1);
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt == 2'd0) || (out_ch.ready && last_beat);
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= PS_GROUND;
      pending_row <= 8'd0;
      cnt <= 2'd0;
      idx <= 2'd0;
    end else begin
      if (in_fire) begin
        parse_state <= dec.state_next;
        pending_row <= dec.pending_row_next;
        cnt <= dec.count;
        idx <= 2'd0;
      end else if (out_fire) begin
        if (last_beat) begin
          cnt <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action <= dec.action;
      row <= dec.row;
      col <= dec.col;
      glyph <= dec.glyph;
      reply1 <= dec.reply1;
    end
  end

  assign out_ch.valid = (cnt != 2'd0);
  assign out_ch.action = action;
  assign out_ch.target_row = row;
  assign out_ch.target_col = col;
  assign out_ch.glyph = glyph;
  assign out_ch.last = last_beat;

  always_comb begin
    out_ch.reply_byte = 8'd0;
    if (action == ACT_REPLY) begin
      case (idx)
        2'd0:    out_ch.reply_byte = CH_ESC;
        2'd1:    out_ch.reply_byte = reply1;
        default: out_ch.reply_byte = ID_K;
      endcase
    end
  end

endmodule

[hw/rtl/vt52_dec.sv]
`timescale 1ns / 1ps
module vt52_dec (
  input  logic              kind,
  input  logic [7:0]        byte_value,
  input  logic [2:0]        key_code,
  input  logic [1:0]        parse_state,
  input  logic [7:0]        pending_row,
  output vt52_pkg::dec_t    dec
);
  import vt52_pkg::*;

  logic [7:0] unbiased;

  assign unbiased = byte_value - POS_BIAS;

  always_comb begin
    dec = '0;
    dec.state_next = parse_state;
    dec.pending_row_next = pending_row;
    if (kind) begin
      // key press leaves the parse state alone
      dec.count = 2'd2;
      dec.action = ACT_REPLY;
      dec.reply1 = key_letter(key_code);
    end else begin
      case (parse_state)
        PS_ESC: begin
          dec.state_next = PS_GROUND;
          case (byte_value)
            SEQ_UP:    begin dec.count = 2'd1; dec.action = ACT_UP; end
            SEQ_DOWN:  begin dec.count = 2'd1; dec.action = ACT_DOWN; end
            SEQ_RIGHT: begin dec.count = 2'd1; dec.action = ACT_RIGHT; end
            SEQ_LEFT:  begin dec.count = 2'd1; dec.action = ACT_LEFT; end
            SEQ_HOME:  begin dec.count = 2'd1; dec.action = ACT_HOME; end
            SEQ_REVLF: begin dec.count = 2'd1; dec.action = ACT_REVLF; end
            SEQ_EOS:   begin dec.count = 2'd1; dec.action = ACT_EOS; end
            SEQ_EOL:   begin dec.count = 2'd1; dec.action = ACT_EOL; end
            SEQ_PLACE: begin dec.state_next = PS_ROW; end
            SEQ_IDENT: begin
              dec.count = 2'd3;
              dec.action = ACT_REPLY;
              dec.reply1 = ID_SLASH;
            end
            default: begin end
          endcase
        end
        PS_ROW: begin
          dec.pending_row_next = unbiased;
          dec.state_next = PS_COL;
        end
        PS_COL: begin
          dec.state_next = PS_GROUND;
          dec.count = 2'd1;
          dec.action = ACT_PLACE;
          dec.row = pending_row;
          dec.col = unbiased;
        end
        default: begin
          dec.state_next = PS_GROUND;
          case (byte_value)
            CH_ESC: dec.state_next = PS_ESC;
            CH_BS:  begin dec.count = 2'd1; dec.action = ACT_BS; end
            CH_HT:  begin dec.count = 2'd1; dec.action = ACT_TAB; end
            CH_LF:  begin dec.count = 2'd1; dec.action = ACT_LF; end
            CH_CR:  begin dec.count = 2'd1; dec.action = ACT_CR; end
            default: begin
              if (!(byte_value inside {[8'h00:8'h1F], CH_DEL})) begin
                dec.count = 2'd1;
                dec.action = ACT_GLYPH;
                dec.glyph = byte_value[6:0];
              end
            end
          endcase
        end
      endcase
    end
  end

endmodule

[verif/vt52_seq_pkg.sv]
`timescale 1ns / 1ps
package vt52_seq_pkg;

  // final letters of the escape sequences; the key replies use the same codes
  localparam logic [7:0] LTR_UP    = 8'h41;
  localparam logic [7:0] LTR_DOWN  = 8'h42;
  localparam logic [7:0] LTR_RIGHT = 8'h43;
  localparam logic [7:0] LTR_LEFT  = 8'h44;
  localparam logic [7:0] LTR_HOME  = 8'h48;
  localparam logic [7:0] LTR_REVLF = 8'h49;
  localparam logic [7:0] LTR_EOS   = 8'h4A;
  localparam logic [7:0] LTR_EOL   = 8'h4B;
  localparam logic [7:0] LTR_PLACE = 8'h59;
  localparam logic [7:0] LTR_IDENT = 8'h5A;
  localparam logic [7:0] LTR_ALTKP = 8'h3D;
  localparam logic [7:0] LTR_GRAPH = 8'h46;

  localparam logic [7:0] ESC_LETTERS [10] = '{LTR_UP, LTR_DOWN, LTR_RIGHT, LTR_LEFT,
                                             LTR_HOME, LTR_REVLF, LTR_EOS, LTR_EOL,
                                             LTR_PLACE, LTR_IDENT};

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] row;
    logic [7:0] col;
    logic [6:0] glyph;
    logic [7:0] reply;
    logic       last;
  } screen_cmd_t;

endpackage

[verif/vt52_escape_parser_checker.sv]
`timescale 1ns / 1ps
module vt52_escape_parser_checker (
  input  logic clk,
  input  logic rst,
  vt52_in_if   in_ch,
  vt52_out_if  out_ch,
  output int   fail_count,
  output int   outstanding
);
  import vt52_pkg::*;
  import vt52_seq_pkg::*;

  screen_cmd_t expected_cmds[$];
  logic [1:0]  parse_phase;
  logic [7:0]  row_latched;
  int          beat_no;

  function automatic screen_cmd_t mk_cmd(input logic [3:0] act, input logic [7:0] row,
                                         input logic [7:0] col, input logic [6:0] gl,
                                         input logic [7:0] rep);
    screen_cmd_t c;
    c.action = act;
    c.row    = row;
    c.col    = col;
    c.glyph  = gl;
    c.reply  = rep;
    c.last   = 1'b0;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] beat %0d: %s", $time, beat_no, msg);
    fail_count++;
  endtask

  task automatic decode_item(input logic kind, input logic [7:0] b, input logic [2:0] key);
    screen_cmd_t cmds[$];
    logic [7:0]  letter;
    if (kind) begin
      // a key press never disturbs the parse state
      case (key)
        KEY_UP:    letter = LTR_UP;
        KEY_DOWN:  letter = LTR_DOWN;
        KEY_RIGHT: letter = LTR_RIGHT;
        KEY_LEFT:  letter = LTR_LEFT;
        KEY_HOME:  letter = LTR_HOME;
        default:   letter = 8'h00;
      endcase
      cmds.push_back(mk_cmd(ACT_REPLY, '0, '0, '0, CH_ESC));
      cmds.push_back(mk_cmd(ACT_REPLY, '0, '0, '0, letter));
    end else begin
      case (parse_phase)
        PS_ESC: begin
          parse_phase = PS_GROUND;
          case (b)
            LTR_UP:    cmds.push_back(mk_cmd(ACT_UP, '0, '0, '0, '0));
            LTR_DOWN:  cmds.push_back(mk_cmd(ACT_DOWN, '0, '0, '0, '0));
            LTR_RIGHT: cmds.push_back(mk_cmd(ACT_RIGHT, '0, '0, '0, '0));
            LTR_LEFT:  cmds.push_back(mk_cmd(ACT_LEFT, '0, '0, '0, '0));
            LTR_HOME:  cmds.push_back(mk_cmd(ACT_HOME, '0, '0, '0, '0));
            LTR_REVLF: cmds.push_back(mk_cmd(ACT_REVLF, '0, '0, '0, '0));
            LTR_EOS:   cmds.push_back(mk_cmd(ACT_EOS, '0, '0, '0, '0));
            LTR_EOL:   cmds.push_back(mk_cmd(ACT_EOL, '0, '0, '0, '0));
            LTR_PLACE: parse_phase = PS_ROW;
            LTR_IDENT: begin
              cmds.push_back(mk_cmd(ACT_REPLY, '0, '0, '0, CH_ESC));
              cmds.push_back(mk_cmd(ACT_REPLY, '0, '0, '0, ID_SLASH));
              cmds.push_back(mk_cmd(ACT_REPLY, '0, '0, '0, ID_K));
            end
            default: ;
          endcase
        end
        PS_ROW: begin
          row_latched = b - POS_BIAS;
          parse_phase = PS_COL;
        end
        PS_COL: begin
          cmds.push_back(mk_cmd(ACT_PLACE, row_latched, b - POS_BIAS, '0, '0));
          parse_phase = PS_GROUND;
        end
        default: begin
          case (b)
            CH_ESC:  parse_phase = PS_ESC;
            CH_BS:   cmds.push_back(mk_cmd(ACT_BS, '0, '0, '0, '0));
            CH_HT:   cmds.push_back(mk_cmd(ACT_TAB, '0, '0, '0, '0));
            CH_LF:   cmds.push_back(mk_cmd(ACT_LF, '0, '0, '0, '0));
            CH_CR:   cmds.push_back(mk_cmd(ACT_CR, '0, '0, '0, '0));
            default: begin
              // other controls and DEL are dropped, high bytes fold to 7 bits
              if (b >= POS_BIAS && b != CH_DEL)
                cmds.push_back(mk_cmd(ACT_GLYPH, '0, '0, b[6:0], '0));
            end
          endcase
        end
      endcase
    end
    if (cmds.size() > 0)
      cmds[cmds.size() - 1].last = 1'b1;
    foreach (cmds[i])
      expected_cmds.push_back(cmds[i]);
  endtask

  task automatic check_beat();
    screen_cmd_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, action 0x%0h", out_ch.action));
    end else begin
      want = expected_cmds.pop_front();
      if (out_ch.action !== want.action)
        report_mismatch($sformatf("action 0x%0h, want 0x%0h", out_ch.action, want.action));
      if (out_ch.target_row !== want.row)
        report_mismatch($sformatf("target_row 0x%0h, want 0x%0h", out_ch.target_row, want.row));
      if (out_ch.target_col !== want.col)
        report_mismatch($sformatf("target_col 0x%0h, want 0x%0h", out_ch.target_col, want.col));
      if (out_ch.glyph !== want.glyph)
        report_mismatch($sformatf("glyph 0x%0h, want 0x%0h", out_ch.glyph, want.glyph));
      if (out_ch.reply_byte !== want.reply)
        report_mismatch($sformatf("reply_byte 0x%0h, want 0x%0h", out_ch.reply_byte,
                                  want.reply));
      if (out_ch.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_phase = PS_GROUND;
      row_latched = 8'h00;
      expected_cmds.delete();
      fail_count = 0;
      beat_no = 0;
    end else begin
      // input first: a beat leaving now is always older than one entering
      if (in_ch.valid && in_ch.ready)
        decode_item(in_ch.kind, in_ch.byte_value, in_ch.key_code);
      if (out_ch.valid && out_ch.ready)
        check_beat();
    end
    outstanding = expected_cmds.size();
  end

endmodule

[verif/vt52_escape_parser_tb.sv]
`timescale 1ns / 1ps
module vt52_escape_parser_tb;
  import vt52_pkg::*;
  import vt52_seq_pkg::*;

  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 120;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   items_sent;
  int   cycle_count;
  bit   idling;
  bit   stall_go;
  bit   hold_off;

  vt52_in_if  in_ch ();
  vt52_out_if out_ch ();

  vt52_escape_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vt52_escape_parser_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    wait (stall_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off && (!idling || $urandom_range(99) >= 35);
    end
  end

  // caller sits at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input logic kind, input logic [7:0] b, input logic [2:0] key);
    while (idling && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.byte_value <= b;
    in_ch.key_code   <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b, 3'($urandom_range(7)));
  endtask

  task automatic send_key(input logic [2:0] key);
    send_item(1'b1, 8'($urandom_range(255)), key);
  endtask

  task automatic send_escape(input logic [7:0] letter);
    send_byte(CH_ESC);
    send_byte(letter);
  endtask

  initial begin
    int       pick;
    int       run_len;
    bit       stall_done;
    logic [7:0] row_b;
    logic [7:0] col_b;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.kind       = 1'b0;
    in_ch.byte_value = 8'h00;
    in_ch.key_code   = 3'd0;
    idling           = 1'b1;
    stall_go         = 1'b0;
    stall_done       = 1'b0;
    items_sent       = 0;
    cycle_count      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lowest printable byte, high bytes, dropped codes and the handled controls
    send_byte(POS_BIAS);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_DEL);
    send_byte(8'h00);
    send_byte(CH_BS);
    send_byte(CH_HT);
    send_byte(CH_LF);
    send_byte(CH_CR);
    foreach (ESC_LETTERS[i]) begin
      if (ESC_LETTERS[i] != LTR_PLACE)
        send_escape(ESC_LETTERS[i]);
    end
    // escape after escape, and the ignored letters
    send_escape(CH_ESC);
    send_escape(LTR_GRAPH);
    send_escape(LTR_ALTKP);
    // place with control bytes as operands and a key press in the middle
    send_escape(LTR_PLACE);
    send_byte(8'h00);
    send_item(1'b1, 8'hFF, 3'd7);
    send_byte(CH_ESC);
    send_key(KEY_HOME);
    send_key(KEY_UP);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 150 && !stall_done) begin
        stall_go   = 1'b1;
        stall_done = 1'b1;
      end
      idling = !(items_sent >= 300 && items_sent < 400);
      pick = $urandom_range(99);
      if (pick < 25) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 45) begin
        send_escape(ESC_LETTERS[$urandom_range(9)]);
      end else if (pick < 57) begin
        if ($urandom_range(3) == 0) begin
          row_b = 8'($urandom_range(255));
          col_b = 8'($urandom_range(255));
        end else begin
          row_b = POS_BIAS + 8'($urandom_range(23));
          col_b = POS_BIAS + 8'($urandom_range(79));
        end
        send_escape(LTR_PLACE);
        send_byte(row_b);
        send_byte(col_b);
      end else if (pick < 67) begin
        case ($urandom_range(5))
          0: send_byte(CH_BS);
          1: send_byte(CH_HT);
          2: send_byte(CH_LF);
          3: send_byte(CH_CR);
          4: send_byte(CH_DEL);
          default: send_byte(8'($urandom_range(8'h1F)));
        endcase
      end else if (pick < 77) begin
        send_key(3'($urandom_range(7)));
      end else if (pick < 84) begin
        send_byte(8'($urandom_range(8'h80, 8'hFF)));
      end else if (pick < 90) begin
        send_byte(CH_ESC);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 95) begin
        // sequence interrupted by a key press
        send_byte(CH_ESC);
        if ($urandom_range(1)) begin
          send_byte(LTR_PLACE);
          send_byte(8'($urandom_range(255)));
        end
        send_key(3'($urandom_range(7)));
        send_byte(8'($urandom_range(255)));
      end else begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 3'($urandom_range(7)));
      end
    end
    in_ch.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
